// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GBLUR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GBLUR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/gblur_pkg.sv -----
// Shared types, constants and helper functions of the 3x3 Gaussian blur stream unit.
package gblur_pkg;

	// Line store depth: the widest image row the unit can hold.
	localparam int MAX_WIDTH = 2048;

	// Field and register widths.
	localparam int PIX_W     = 8;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;

	// Column counter and line store address width.
	localparam int COL_W  = $clog2(MAX_WIDTH);
	// Working width for column, row and width arithmetic.
	localparam int POS_W  = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
	// Count of results still owed after a frame ends (up to width + 1).
	localparam int PEND_W = $clog2(MAX_WIDTH + 2);

	// One line store word holds the upper and the middle row pixel of a column.
	localparam int LINE_W = 2 * PIX_W;

	// Filter arithmetic widths.
	localparam int ROW_W       = PIX_W + 2;
	localparam int SUM_W       = PIX_W + 4;
	localparam int NUM_W       = SUM_W + 1;
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = NUM_W + RECIP_W;

	// Configuration reset values and the largest width that is kept.
	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
	localparam logic [CFG_W-1:0] WIDTH_LIMIT  =
		CFG_W'((MAX_WIDTH > (1 << CFG_W) - 1) ? (1 << CFG_W) - 1 : MAX_WIDTH);

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Per-beat control decoded at the input and carried to the filter stage.
	typedef struct packed {
		logic             emit;
		logic             shift;
		logic             wr;
		logic             top_ok;
		logic             bot_ok;
		logic             left_ok;
		logic             right_ok;
		logic             frame_end;
		logic [COL_W-1:0] addr;
	} op_t;

	// Power of two in a per-axis weight total (2, 3 or 4).
	function automatic logic [1:0] twos_of(input logic [2:0] axis_total);
		case (axis_total)
			3'd4:    twos_of = 2'd2;
			3'd3:    twos_of = 2'd0;
			default: twos_of = 2'd1;
		endcase
	endfunction

	// Reciprocal in units of 2^-16 for a divisor of 1, 3 or 9.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] threes);
		case (threes)
			2'd1:    recip_of = RECIP_W'(21846);
			2'd2:    recip_of = RECIP_W'(7282);
			default: recip_of = RECIP_W'(65536);
		endcase
	endfunction

endpackage

// ----- src/gblur_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module gblur_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- src/gaussian_blur_3x3_stream_unit.sv -----
// A result passes the filter stage register and the output register after the beat that completes its 3x3 window.
// Throughput: one input beat per cycle while the output is not stalled; the window needs image_width + 1 further beats.
// The line store RAM takes one read and one write per cycle, which sets that rate.
// Reset clears counters, window and handshake state and sets the size to 640 x 480.
// Line store contents are not cleared; border pixels never read unwritten entries.
module gaussian_blur_3x3_stream_unit (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_write,
	input  logic [gblur_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [gblur_pkg::CFG_W-1:0]               cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic                                      cmd,
	input  logic [gblur_pkg::PIX_W-1:0]               pixel_in,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [gblur_pkg::PIX_W-1:0]               blurred,
	output logic                                      frame_end
);

	// Configuration and raster position.
	logic [gblur_pkg::CFG_W-1:0]  img_w_q;
	logic [gblur_pkg::CFG_W-1:0]  img_h_q;
	logic [gblur_pkg::COL_W-1:0]  col_q;
	logic [gblur_pkg::CFG_W-1:0]  row_q;
	logic [gblur_pkg::PEND_W-1:0] pend_q;
	logic [gblur_pkg::CFG_W-1:0]  width_clamped;
	logic [gblur_pkg::CFG_W-1:0]  height_clamped;

	// Input decode.
	logic                         in_acc;
	logic                         is_flush;
	logic                         pend_zero;
	logic                         load_s1;
	logic                         col_first;
	logic [gblur_pkg::POS_W-1:0]  wid;
	logic [gblur_pkg::POS_W-1:0]  hgt;
	logic [gblur_pkg::POS_W-1:0]  col_pos;
	logic [gblur_pkg::POS_W-1:0]  row_pos;
	logic [gblur_pkg::POS_W-1:0]  pend_pos;
	logic [gblur_pkg::POS_W-1:0]  jcol;
	logic [gblur_pkg::COL_W-1:0]  col_nxt;
	logic [gblur_pkg::CFG_W-1:0]  row_nxt;
	logic [gblur_pkg::PEND_W-1:0] pend_nxt;
	gblur_pkg::op_t               op_d;

	// Filter stage.
	logic                         s1_valid;
	logic                         s1_fire;
	gblur_pkg::op_t               op_s1;
	logic [gblur_pkg::PIX_W-1:0]  pix_s1;
	logic                         byp_s1;
	logic [gblur_pkg::LINE_W-1:0] byp_data_s1;
	logic [gblur_pkg::LINE_W-1:0] ram_rd_data;
	logic [gblur_pkg::LINE_W-1:0] line_s1;
	logic [gblur_pkg::LINE_W-1:0] wr_data;
	logic [gblur_pkg::PIX_W-1:0]  new_col [3];
	logic [gblur_pkg::PIX_W-1:0]  win_a_q [3];
	logic [gblur_pkg::PIX_W-1:0]  win_b_q [3];

	// Filter arithmetic.
	logic [gblur_pkg::ROW_W-1:0]  row_sum [3];
	logic [gblur_pkg::SUM_W-1:0]  wsum;
	logic [2:0]                   rows_w;
	logic [2:0]                   cols_w;
	logic [4:0]                   total_w;
	logic [2:0]                   pow2_n;
	logic [1:0]                   threes_n;
	logic [gblur_pkg::NUM_W-1:0]  num;
	logic [gblur_pkg::NUM_W-1:0]  quo_in;
	logic [gblur_pkg::PROD_W-1:0] prod;

	// Output register.
	logic                         out_valid_q;
	logic [gblur_pkg::PIX_W-1:0]  blurred_q;
	logic                         frame_end_q;

	// Handshake.
	assign in_acc    = in_valid && in_ready;
	assign is_flush  = (cmd == gblur_pkg::CMD_FLUSH);
	assign pend_zero = (pend_q == '0);
	// A flush beat with nothing owed changes nothing and never enters the filter stage.
	assign load_s1   = in_acc && !(is_flush && pend_zero);
	assign s1_fire   = s1_valid && (!op_s1.emit || !out_valid_q || out_ready);
	assign in_ready  = !s1_valid || s1_fire;

	// Written sizes are forced into their legal ranges.
	always_comb begin
		if (cfg_data == '0) begin
			width_clamped = gblur_pkg::CFG_W'(1);
		end else if (cfg_data > gblur_pkg::WIDTH_LIMIT) begin
			width_clamped = gblur_pkg::WIDTH_LIMIT;
		end else begin
			width_clamped = cfg_data;
		end
		height_clamped = (cfg_data == '0) ? gblur_pkg::CFG_W'(1) : cfg_data;
	end

	assign wid      = gblur_pkg::POS_W'(img_w_q);
	assign hgt      = gblur_pkg::POS_W'(img_h_q);
	assign col_pos  = gblur_pkg::POS_W'(col_q);
	assign row_pos  = gblur_pkg::POS_W'(row_q);
	assign pend_pos = gblur_pkg::POS_W'(pend_q);

	// Decode the beat: which result it produces, the border flags and the next position.
	always_comb begin
		op_d      = '0;
		col_nxt   = col_q;
		row_nxt   = row_q;
		pend_nxt  = pend_q;
		col_first = (col_pos == '0);
		// Column being drained after the frame's last pixel.
		jcol      = wid + gblur_pkg::POS_W'(1) - pend_pos;
		if (!is_flush) begin
			// At the first column the window still holds the last column two rows up.
			op_d.emit      = col_first ? (row_pos >= gblur_pkg::POS_W'(2))
			                           : (row_pos >= gblur_pkg::POS_W'(1));
			op_d.shift     = 1'b1;
			op_d.wr        = 1'b1;
			op_d.top_ok    = col_first ? (row_pos >= gblur_pkg::POS_W'(3))
			                           : (row_pos >= gblur_pkg::POS_W'(2));
			op_d.bot_ok    = 1'b1;
			op_d.left_ok   = col_first ? (wid >= gblur_pkg::POS_W'(2))
			                           : (col_pos >= gblur_pkg::POS_W'(2));
			op_d.right_ok  = !col_first;
			op_d.frame_end = 1'b0;
			op_d.addr      = col_q;
			pend_nxt       = '0;
			if (col_pos + gblur_pkg::POS_W'(1) >= wid) begin
				col_nxt = '0;
				if (row_pos + gblur_pkg::POS_W'(1) >= hgt) begin
					row_nxt  = '0;
					pend_nxt = (hgt >= gblur_pkg::POS_W'(2))
					           ? gblur_pkg::PEND_W'(wid + gblur_pkg::POS_W'(1))
					           : gblur_pkg::PEND_W'(wid);
				end else begin
					row_nxt = row_q + 1'b1;
				end
			end else begin
				col_nxt = col_q + 1'b1;
			end
		end else if (!pend_zero) begin
			op_d.emit = 1'b1;
			op_d.addr = jcol[gblur_pkg::COL_W-1:0];
			pend_nxt  = pend_q - 1'b1;
			if (jcol == '0) begin
				// Last column of the second-to-last row, then load the first column.
				op_d.shift    = 1'b1;
				op_d.top_ok   = (hgt >= gblur_pkg::POS_W'(3));
				op_d.bot_ok   = 1'b1;
				op_d.left_ok  = (wid >= gblur_pkg::POS_W'(2));
				op_d.right_ok = 1'b0;
			end else if (jcol < wid) begin
				// Last row, next column loaded from the line store.
				op_d.shift    = 1'b1;
				op_d.top_ok   = (hgt >= gblur_pkg::POS_W'(2));
				op_d.bot_ok   = 1'b0;
				op_d.left_ok  = (jcol >= gblur_pkg::POS_W'(2));
				op_d.right_ok = 1'b1;
			end else begin
				// Final pixel of the frame.
				op_d.shift     = 1'b0;
				op_d.top_ok    = (hgt >= gblur_pkg::POS_W'(2));
				op_d.bot_ok    = 1'b0;
				op_d.left_ok   = (wid >= gblur_pkg::POS_W'(2));
				op_d.right_ok  = 1'b0;
				op_d.frame_end = 1'b1;
			end
		end
	end

	// Configuration registers and raster counters; a register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= gblur_pkg::WIDTH_RESET;
			img_h_q <= gblur_pkg::HEIGHT_RESET;
			col_q   <= '0;
			row_q   <= '0;
			pend_q  <= '0;
		end else if (cfg_write) begin
			case (gblur_pkg::cfg_reg_t'(cfg_index))
				gblur_pkg::REG_IMAGE_WIDTH: begin
					img_w_q <= width_clamped;
				end
				gblur_pkg::REG_IMAGE_HEIGHT: begin
					img_h_q <= height_clamped;
				end
				default: begin
					img_w_q <= img_w_q;
				end
			endcase
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (in_acc) begin
			col_q  <= col_nxt;
			row_q  <= row_nxt;
			pend_q <= pend_nxt;
		end
	end

	// Filter stage control, including the forward of a write that hit the address just read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			if (load_s1) begin
				s1_valid <= 1'b1;
				byp_s1   <= s1_fire && op_s1.wr && (op_s1.addr == op_d.addr);
			end else if (s1_fire) begin
				s1_valid <= 1'b0;
			end
		end
	end

	// Filter stage payload.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1       <= op_d;
			pix_s1      <= is_flush ? '0 : pixel_in;
			byp_data_s1 <= wr_data;
		end
	end

	// Upper and middle rows share one line store word per column.
	assign line_s1 = byp_s1 ? byp_data_s1 : ram_rd_data;
	assign wr_data = {line_s1[gblur_pkg::PIX_W-1:0], pix_s1};

	gblur_ram #(
		.DATA_W (gblur_pkg::LINE_W),
		.DEPTH  (gblur_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (s1_fire && op_s1.wr),
		.wr_addr (op_s1.addr),
		.wr_data (wr_data),
		.rd_en   (load_s1 && op_d.shift),
		.rd_addr (op_d.addr),
		.rd_data (ram_rd_data)
	);

	assign new_col[0] = line_s1[gblur_pkg::LINE_W-1:gblur_pkg::PIX_W];
	assign new_col[1] = line_s1[gblur_pkg::PIX_W-1:0];
	assign new_col[2] = pix_s1;

	// Window of the two newest columns; the oldest one is never needed again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_a_q[i] <= '0;
				win_b_q[i] <= '0;
			end
		end else if (s1_fire && op_s1.shift) begin
			for (int i = 0; i < 3; i++) begin
				win_a_q[i] <= win_b_q[i];
				win_b_q[i] <= new_col[i];
			end
		end
	end

	// Weighted 1-2-1 sums per row, skipping neighbors outside the image.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_sum[i] = {1'b0, win_b_q[i], 1'b0};
			if (op_s1.left_ok) begin
				row_sum[i] = row_sum[i] + gblur_pkg::ROW_W'(win_a_q[i]);
			end
			if (op_s1.right_ok) begin
				row_sum[i] = row_sum[i] + gblur_pkg::ROW_W'(new_col[i]);
			end
		end
		wsum = {1'b0, row_sum[1], 1'b0};
		if (op_s1.top_ok) begin
			wsum = wsum + gblur_pkg::SUM_W'(row_sum[0]);
		end
		if (op_s1.bot_ok) begin
			wsum = wsum + gblur_pkg::SUM_W'(row_sum[2]);
		end
	end

	// Divide by the in-bounds weight total, rounding half up: floor((2S + T) / 2T).
	// 2T factors into a power of two (a shift) and 1, 3 or 9 (a reciprocal multiply).
	always_comb begin
		rows_w = 3'd2 + {2'b00, op_s1.top_ok} + {2'b00, op_s1.bot_ok};
		cols_w = 3'd2 + {2'b00, op_s1.left_ok} + {2'b00, op_s1.right_ok};
		case (rows_w)
			3'd4:    total_w = {cols_w, 2'b00};
			3'd3:    total_w = {1'b0, cols_w, 1'b0} + {2'b00, cols_w};
			default: total_w = {1'b0, cols_w, 1'b0};
		endcase
		pow2_n   = 3'd1 + {1'b0, gblur_pkg::twos_of(rows_w)}
		                + {1'b0, gblur_pkg::twos_of(cols_w)};
		threes_n = {1'b0, (rows_w == 3'd3)} + {1'b0, (cols_w == 3'd3)};
		num      = {wsum, 1'b0} + gblur_pkg::NUM_W'(total_w);
		quo_in   = num >> pow2_n;
		prod     = gblur_pkg::PROD_W'(quo_in)
		           * gblur_pkg::PROD_W'(gblur_pkg::recip_of(threes_n));
	end

	// Output register: holds a result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && op_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && op_s1.emit) begin
			blurred_q   <= prod[gblur_pkg::RECIP_SHIFT +: gblur_pkg::PIX_W];
			frame_end_q <= op_s1.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign blurred   = blurred_q;
	assign frame_end = frame_end_q;

endmodule

// ----- src/gblur_checker.sv -----
// Port-level checker for the blur stream unit, bound to the top level.
`include "assert_macros.svh"

module gblur_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [gblur_pkg::PIX_W-1:0] blurred,
	input logic                        frame_end
);

	// A stalled result beat keeps its payload.
	`GBLUR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(blurred) && $stable(frame_end), "stalled result beat changed")

	// The input side only stalls behind a result that is waiting to be taken.
	`GBLUR_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready, "input stalled without a held result")

	// A result appearing on an empty output comes from an accepted beat, by way of the filter stage register.
	`GBLUR_ASSERT_NOW(a_result_source, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without an accepted beat")

	// No result is shown right after reset.
	`GBLUR_ASSERT_NOW(a_reset_empty, clk, arst_n, $rose(arst_n), !out_valid, "result valid straight out of reset")

endmodule

bind gaussian_blur_3x3_stream_unit gblur_checker u_gblur_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.blurred   (blurred),
	.frame_end (frame_end)
);
